/* src/spq_pkg.sv */
// package for the scan-dequeue priority queue: entry type, operation and status codes,
// sequencer states and the compare unit control group; no dependencies
`timescale 1ns / 1ps

package spq_pkg;

  localparam int unsigned DEPTH_DEF = 8;
  localparam int unsigned DATA_W    = 32;

  typedef enum logic [1:0] {
    FN_ENQ  = 2'd0,
    FN_DEQ  = 2'd1,
    FN_PEEK = 2'd2,
    FN_REAR = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_OVERFLOW  = 2'd1,
    STS_UNDERFLOW = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_REAR,
    S_DONE
  } state_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    logic signed [DATA_W-1:0] prio;
  } entry_t;

  typedef struct packed {
    logic en;
    logic first;
  } cmp_ctrl_t;

endpackage

/* src/spq_best_sel.sv */
// shared priority comparator with the running best-entry register of a scan
// depends on spq_pkg
`timescale 1ns / 1ps

module spq_best_sel #(
  parameter int unsigned AW = 3
) (
  input  logic                clk_i,
  input  spq_pkg::cmp_ctrl_t  ctrl_i,
  input  logic [AW-1:0]       cand_idx_i,
  input  spq_pkg::entry_t     cand_i,
  output logic [AW-1:0]       best_idx_o,
  output spq_pkg::entry_t     best_o
);
  import spq_pkg::*;

  entry_t        best_q;
  logic [AW-1:0] best_idx_q;
  logic          take;

  // strict less keeps the earliest entry on a tie
  assign take       = ctrl_i.first || (cand_i.prio < best_q.prio);
  assign best_o     = take ? cand_i : best_q;
  assign best_idx_o = take ? cand_idx_i : best_idx_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      best_q     <= best_o;
      best_idx_q <= best_idx_o;
    end
  end

endmodule

/* src/scan_dequeue_priority_queue.sv */
// Bounded priority queue of (data, priority) entries held in arrival order.
// Input channel in_valid_i/in_ready_o carries one request: func_i selects
// enqueue, dequeue lowest, peek lowest or read last appended; item_data_i and
// item_priority_i are stored by enqueue. Output channel out_valid_o/out_ready_i
// returns one result per request: data, priority, status and occupancy.
// Enqueue, and any request refused on an empty or full queue, goes straight to
// the result; rear first reads the last entry; peek scans all count entries for
// the lowest priority, and dequeue then moves the entries behind it down one place.
// The sequencer works on one request at a time: a new request is taken only once
// the last result has entered the output register. The priority scan runs through
// one comparator and the entry memory (one read port, one write port).
// Reset clears the entry count and the sequencer; the queue is empty after it.
// The result sits in an output register; while the receiver stalls, the next
// request is still taken, and its result waits in the sequencer until the
// output register is free.
// depends on spq_pkg and spq_best_sel
`timescale 1ns / 1ps

module scan_dequeue_priority_queue #(
  parameter int unsigned DEPTH = spq_pkg::DEPTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [1:0]                         func_i,
  input  logic signed [spq_pkg::DATA_W-1:0]  item_data_i,
  input  logic signed [spq_pkg::DATA_W-1:0]  item_priority_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [spq_pkg::DATA_W-1:0]  out_data_o,
  output logic signed [spq_pkg::DATA_W-1:0]  out_priority_o,
  output logic [1:0]                         status_o,
  output logic [3:0]                         occupancy_o
);
  import spq_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  state_e        state_q, state_d;
  func_e         op_q, op_d;
  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] idx_q, idx_d;
  logic          idx_last;

  entry_t        entry_mem [DEPTH];
  entry_t        rd_entry_q;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic          wr_en;
  entry_t        wr_entry;

  entry_t        res_q, res_d;
  status_e       res_status_q, res_status_d;

  cmp_ctrl_t     cmp_ctrl;
  logic [AW-1:0] best_idx;
  entry_t        best;

  logic          load_out;
  logic          out_valid_q;
  entry_t        out_q;
  status_e       out_status_q;
  logic [3:0]    out_occ_q;

  spq_best_sel #(
    .AW(AW)
  ) u_best_sel (
    .clk_i      (clk_i),
    .ctrl_i     (cmp_ctrl),
    .cand_idx_i (idx_q),
    .cand_i     (rd_entry_q),
    .best_idx_o (best_idx),
    .best_o     (best)
  );

  // entry memory
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      entry_mem[wr_addr] <= wr_entry;
    end
    rd_entry_q <= entry_mem[rd_addr];
  end

  assign idx_last = (CW'(idx_q) == (count_q - CW'(1)));

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    count_d      = count_q;
    idx_d        = idx_q;
    res_d        = res_q;
    res_status_d = res_status_q;
    rd_addr      = idx_q + AW'(1);
    wr_en        = 1'b0;
    wr_addr      = idx_q - AW'(1);
    wr_entry     = rd_entry_q;
    cmp_ctrl     = '{en: 1'b0, first: (idx_q == '0)};
    load_out     = 1'b0;
    in_ready_o   = (state_q == S_IDLE);

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          res_d        = '0;
          res_status_d = STS_OK;
          state_d      = S_DONE;
          if (func_e'(func_i) == FN_ENQ) begin
            if (count_q == FULL) begin
              res_status_d = STS_OVERFLOW;
            end else begin
              wr_en    = 1'b1;
              wr_addr  = AW'(count_q);
              wr_entry = '{data: item_data_i, prio: item_priority_i};
              count_d  = count_q + CW'(1);
            end
          end else if (count_q == '0) begin
            res_status_d = STS_UNDERFLOW;
          end else if (func_e'(func_i) == FN_REAR) begin
            rd_addr = AW'(count_q - CW'(1));
            state_d = S_REAR;
          end else begin
            rd_addr = '0;
            idx_d   = '0;
            op_d    = func_e'(func_i);
            state_d = S_SCAN;
          end
        end
      end
      S_REAR: begin
        res_d   = rd_entry_q;
        state_d = S_DONE;
      end
      S_SCAN: begin
        cmp_ctrl.en = 1'b1;
        idx_d       = idx_q + AW'(1);
        if (idx_last) begin
          res_d   = best;
          state_d = S_DONE;
          if (op_q == FN_DEQ) begin
            if (best_idx == idx_q) begin
              count_d = count_q - CW'(1);
            end else begin
              rd_addr = best_idx + AW'(1);
              idx_d   = best_idx + AW'(1);
              state_d = S_SHIFT;
            end
          end
        end
      end
      S_SHIFT: begin
        // move entry idx down by one place
        wr_en = 1'b1;
        idx_d = idx_q + AW'(1);
        if (idx_last) begin
          count_d = count_q - CW'(1);
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= FN_PEEK;
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q        <= res_d;
    res_status_q <= res_status_d;
    if (load_out) begin
      out_q        <= res_q;
      out_status_q <= res_status_q;
      out_occ_q    <= 4'(count_q);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_q.data;
  assign out_priority_o = out_q.prio;
  assign status_o       = out_status_q;
  assign occupancy_o    = out_occ_q;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FULL)
    else $error("entry count beyond depth");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(count_q) |->
      (count_q == $past(count_q) + CW'(1)) || (count_q == $past(count_q) - CW'(1)))
    else $error("entry count moved by more than one");

  a_enq_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (func_e'(func_i) == FN_ENQ) && (count_q != FULL)
      |=> count_q == $past(count_q) + CW'(1))
    else $error("enqueue did not add an entry");

  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) || (state_q == S_SHIFT) |-> CW'(idx_q) < count_q)
    else $error("scan index past held entries");
`endif

endmodule

/* dv/testbench.sv */
// self-checking testbench for scan_dequeue_priority_queue: directed and random requests
// on both valid/ready channels, results predicted in-bench and checked field by field
// depends on spq_pkg and the queue rtl
`timescale 1ns / 1ps

module testbench;
  import spq_pkg::*;

  localparam int unsigned QUEUE_DEPTH = DEPTH_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_REQUESTS = 1900;
  localparam int QUIET_FIRST = 600;
  localparam int QUIET_LAST = 900;
  localparam int SETTLE_CYCLES = 16;

  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    logic signed [DATA_W-1:0] prio;
    status_e                  status;
    logic [3:0]               occupancy;
  } queue_result_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      in_valid_i = 1'b0;
  logic                      in_ready_o;
  logic [1:0]                func_i = FN_ENQ;
  logic signed [DATA_W-1:0]  item_data_i = '0;
  logic signed [DATA_W-1:0]  item_priority_i = '0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  logic signed [DATA_W-1:0]  out_data_o;
  logic signed [DATA_W-1:0]  out_priority_o;
  logic [1:0]                status_o;
  logic [3:0]                occupancy_o;

  entry_t        held_entries[QUEUE_DEPTH];
  int unsigned   held_count = 0;
  queue_result_t pending_results[$];

  bit idle_on = 1'b1;
  int hold_left = 0;
  int cycle_count = 0;
  int errors = 0;
  int requests_sent = 0;
  int results_seen = 0;
  int op_counts[4] = '{default: 0};
  int overflow_count = 0;
  int underflow_count = 0;

  scan_dequeue_priority_queue #(.DEPTH(QUEUE_DEPTH)) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .func_i          (func_i),
    .item_data_i     (item_data_i),
    .item_priority_i (item_priority_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_data_o      (out_data_o),
    .out_priority_o  (out_priority_o),
    .status_o        (status_o),
    .occupancy_o     (occupancy_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // applies one request to the held entries and returns the result it causes
  function automatic queue_result_t apply_queue_op(func_e op, logic signed [DATA_W-1:0] d,
                                                   logic signed [DATA_W-1:0] p);
    queue_result_t res;
    int unsigned   sel;
    res = '{data: '0, prio: '0, status: STS_OK, occupancy: '0};
    sel = 0;
    if (op == FN_ENQ) begin
      if (held_count >= QUEUE_DEPTH) begin
        res.status = STS_OVERFLOW;
      end else begin
        held_entries[held_count] = '{data: d, prio: p};
        held_count++;
      end
    end else if (held_count == 0) begin
      res.status = STS_UNDERFLOW;
    end else if (op == FN_REAR) begin
      res.data = held_entries[held_count-1].data;
      res.prio = held_entries[held_count-1].prio;
    end else begin
      for (int unsigned i = 1; i < held_count; i++) begin
        if ($signed(held_entries[i].prio) < $signed(held_entries[sel].prio)) sel = i;
      end
      res.data = held_entries[sel].data;
      res.prio = held_entries[sel].prio;
      if (op == FN_DEQ) begin
        for (int unsigned i = sel; i + 1 < held_count; i++) begin
          held_entries[i] = held_entries[i+1];
        end
        held_count--;
      end
    end
    res.occupancy = held_count[3:0];
    return res;
  endfunction

  task automatic send_request(func_e op, logic signed [DATA_W-1:0] d,
                              logic signed [DATA_W-1:0] p);
    queue_result_t res;
    if (idle_on && $urandom_range(99) < 7) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    func_i          <= op;
    item_data_i     <= d;
    item_priority_i <= p;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    res = apply_queue_op(op, d, p);
    pending_results.push_back(res);
    requests_sent++;
    op_counts[op]++;
    if (res.status == STS_OVERFLOW) overflow_count++;
    if (res.status == STS_UNDERFLOW) underflow_count++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_priority();
    case ($urandom_range(9))
      6, 7:    return $urandom;
      8:       return 32'sh8000_0000;
      9:       return 32'sh7fff_ffff;
      default: return $signed($urandom_range(6)) - 3;
    endcase
  endfunction

  task automatic test_empty_queue();
    send_request(FN_DEQ, 32'sh1234_5678, 32'sh0000_0001);
    send_request(FN_PEEK, 32'shffff_ffff, 32'sh8000_0000);
    send_request(FN_REAR, 32'sh7fff_ffff, 32'sh7fff_ffff);
  endtask

  // extremes of data and priority, ties, overflow, then drain past empty
  task automatic test_fill_and_overflow();
    logic signed [DATA_W-1:0] fill_data[8];
    logic signed [DATA_W-1:0] fill_prio[8];
    fill_data = '{32'sh8000_0000, 32'sh7fff_ffff, 32'shffff_ffff, 32'sh0000_0000,
                  32'sha5a5_a5a5, 32'sh5a5a_5a5a, 32'sh0000_0001, 32'shfffe_0000};
    fill_prio = '{32'sh7fff_ffff, 32'sh0000_0005, 32'sh8000_0000, 32'shffff_ffff,
                  32'sh0000_0005, 32'sh8000_0000, 32'sh0000_0000, 32'sh7fff_ffff};
    for (int i = 0; i < 8; i++) send_request(FN_ENQ, fill_data[i], fill_prio[i]);
    send_request(FN_ENQ, 32'sh0bad_0bad, 32'sh8000_0000);
    send_request(FN_PEEK, '0, '0);
    send_request(FN_REAR, '0, '0);
    for (int i = 0; i < 8; i++) send_request(FN_DEQ, $urandom, $urandom);
    send_request(FN_DEQ, '0, '0);
    wait_drained();
  endtask

  // receiver holds off while requests keep coming, so the input stalls
  task automatic test_output_backpressure();
    hold_left = HOLD_CYCLES;
    for (int i = 0; i < 12; i++) begin
      if (i % 3 == 2) send_request(FN_PEEK, $urandom, $urandom);
      else send_request(FN_ENQ, $urandom, pick_priority());
    end
    wait_drained();
  endtask

  task automatic test_random_traffic();
    bit    filling;
    func_e op;
    int    roll;
    filling = 1'b1;
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      idle_on = !(n >= QUIET_FIRST && n < QUIET_LAST);
      if (held_count == QUEUE_DEPTH && $urandom_range(3) != 0) filling = 1'b0;
      if (held_count == 0 && $urandom_range(3) != 0) filling = 1'b1;
      if ($urandom_range(19) == 0) filling = !filling;
      roll = $urandom_range(99);
      if (roll < 10) op = func_e'($urandom_range(3));
      else if (filling) op = (roll < 75) ? FN_ENQ : func_e'($urandom_range(3, 1));
      else if (roll < 30) op = FN_ENQ;
      else if (roll < 70) op = FN_DEQ;
      else if (roll < 85) op = FN_PEEK;
      else op = FN_REAR;
      send_request(op, $urandom, pick_priority());
      if (n == RANDOM_REQUESTS / 2) wait_drained();
    end
    idle_on = 1'b1;
    wait_drained();
  endtask

  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left   <= hold_left - 1;
    end else begin
      out_ready_i <= !(idle_on && $urandom_range(99) < 7);
    end
  end

  task automatic compare_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, $signed(want),
               $signed(got));
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    queue_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: result with none expected, expected nothing, got data %0d prio %0d",
                 $time, out_data_o, out_priority_o);
        errors++;
      end else begin
        want = pending_results.pop_front();
        compare_field("out_data", want.data, out_data_o);
        compare_field("out_priority", want.prio, out_priority_o);
        compare_field("status", 32'(want.status), 32'(status_o));
        compare_field("occupancy", 32'(want.occupancy), 32'(occupancy_o));
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("scan_dequeue_priority_queue verification failed");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_queue();
    test_fill_and_overflow();
    test_output_backpressure();
    test_random_traffic();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_results.size());
      errors++;
    end
    $display("requests %0d (enq %0d, deq %0d, peek %0d, rear %0d), results %0d",
             requests_sent, op_counts[FN_ENQ], op_counts[FN_DEQ], op_counts[FN_PEEK],
             op_counts[FN_REAR], results_seen);
    $display("overflows %0d, underflows %0d, errors %0d", overflow_count, underflow_count,
             errors);
    if (errors == 0) begin
      $display("scan_dequeue_priority_queue verification clean");
    end else begin
      $display("scan_dequeue_priority_queue verification failed");
    end
    $finish;
  end

endmodule

/* scan_dequeue_priority_queue.f */
src/spq_pkg.sv
src/spq_best_sel.sv
src/scan_dequeue_priority_queue.sv
dv/testbench.sv
